// ===== rtl/port_access_rule_matcher_assert.svh =====
// Assertion macros used by the port access rule matcher top level.
`ifndef PORT_ACCESS_RULE_MATCHER_ASSERT_SVH
`define PORT_ACCESS_RULE_MATCHER_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define PARM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("port access rule matcher check failed");

// Same-cycle implication.
`define PARM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("port access rule matcher check failed");

// Next-cycle implication.
`define PARM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("port access rule matcher check failed");

`else

`define PARM_ASSERT(lbl, clk, rst_n, prop)
`define PARM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PARM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/parm_pkg.sv =====
// Types, constants and sizes shared by the port access rule matcher modules.
package parm_pkg;

	localparam int RULES     = 1024;
	localparam int RULE_AW   = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int TOTAL_W   = $clog2(RULES + 1);
	localparam int MAP_WORDS = 2048;
	localparam int MAP_AW    = $clog2(MAP_WORDS);

	localparam logic [1:0] ACT_RULE  = 2'd0;
	localparam logic [1:0] ACT_COUNT = 2'd1;
	localparam logic [1:0] ACT_MAP   = 2'd2;
	localparam logic [1:0] ACT_CHECK = 2'd3;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// Flag byte bit positions.
	localparam int F_TCP4 = 0;
	localparam int F_UDP4 = 1;
	localparam int F_TCP6 = 2;
	localparam int F_UDP6 = 3;
	localparam int F_UID  = 4;
	localparam int F_GRP  = 5;
	localparam int F_LOG  = 6;
	localparam int F_DENY = 7;

	// Request payload, last field in the lowest bits.
	typedef struct packed {
		logic [2:0]  pad;
		logic        has_bind_cap;
		logic [7:0]  protocol;
		logic        is_ipv6;
		logic [31:0] word_data;
		logic [31:0] extra_group;
		logic [31:0] group_id;
		logic [31:0] user_id;
		logic [7:0]  rule_flags;
		logic [15:0] port_end;
		logic [15:0] port;
		logic [10:0] index;
	} req_t;

	// One stored rule.
	typedef struct packed {
		logic [7:0]  flags;
		logic [31:0] gid;
		logic [31:0] uid;
		logic [15:0] lo;
		logic [15:0] hi;
	} rule_t;

	// Outcome of testing one rule against the latched request.
	typedef struct packed {
		logic hit;
		logic deny;
		logic log;
	} eval_t;

	// Result item, last field in the lowest bits.
	typedef struct packed {
		logic [9:0] rule_hit;
		logic       by_default;
		logic       log_hit;
		logic       verdict;
	} res_t;

endpackage

// ===== rtl/port_access_rule_matcher.sv =====
// Top level of the port access rule matcher: request sequencer, rule walk and default map.
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+--------------------------------------------
//  s       | in        | s_tvalid/s_tready| s_tuser = action, s_tdata = request fields
//  m       | out       | m_tvalid/m_tready| m_tdata = verdict, log_hit, by_default, hit
//
// Rule writes, rule count writes and default map writes take the request and write it;
// the all-zero result is then loaded into the output register once that register is free.
// A check walks the rule memory one rule per cycle through its single read port; if no
// rule decides it, it falls through to the default map, read from the map memory. After
// reset the default map memory is cleared one word a cycle, and no request is taken
// during that pass.
// The output register lets a new request be taken while a result still waits; a
// finished result is held inside the block only when that register is also full.
// Reads and writes of either memory never overlap: writes are done only when a request is
// taken or during the clearing pass, and reads only while a check is in progress.
`include "port_access_rule_matcher_assert.svh"

module port_access_rule_matcher (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// From bit 0: index, port, port_end, rule_flags, user_id, group_id, extra_group,
	// word_data, is_ipv6, protocol, has_bind_cap, then zero fill.
	input  logic [191:0] s_tdata,
	// action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// From bit 0: verdict, log_hit, by_default, rule_hit, then zero fill.
	output logic [15:0]  m_tdata
);

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_WALK   = 3'd2;
	localparam logic [2:0] ST_MAPRD  = 3'd3;
	localparam logic [2:0] ST_MAPCHK = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]                      state_q;
	logic [parm_pkg::MAP_AW-1:0]     clr_q;
	logic [parm_pkg::TOTAL_W-1:0]    total_q;
	logic [parm_pkg::TOTAL_W-1:0]    issue_q;
	logic                            ev_v_s1;
	logic [parm_pkg::RULE_AW-1:0]    ev_idx_s1;
	logic                            log_q;
	logic                            m_valid_q;
	parm_pkg::req_t                  req_q;
	parm_pkg::res_t                  res_q;
	parm_pkg::res_t                  out_q;

	parm_pkg::req_t                  s_req;
	logic                            acc;
	logic                            idx_ok;
	logic                            decide;
	logic                            out_load;

	logic                            rule_we;
	logic [parm_pkg::RULE_AW-1:0]    rule_waddr;
	parm_pkg::rule_t                 rule_wdata;
	logic                            rule_re;
	logic [parm_pkg::RULE_AW-1:0]    rule_raddr;
	parm_pkg::rule_t                 rule_rdata;

	logic                            map_we;
	logic [parm_pkg::MAP_AW-1:0]     map_waddr;
	logic [31:0]                     map_wdata;
	logic                            map_re;
	logic [parm_pkg::MAP_AW-1:0]     map_raddr;
	logic [31:0]                     map_rdata;

	parm_pkg::eval_t                 ev;
	logic [parm_pkg::TOTAL_W-1:0]    total_d;

	assign s_req    = parm_pkg::req_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, out_q};

	// The finished result moves into the output register once that register is free.
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	// Rule writes beyond the table are dropped; a count above the table saturates.
	assign idx_ok  = (32'(s_req.index) < 32'(parm_pkg::RULES));
	assign total_d = (s_req.word_data > 32'(parm_pkg::RULES)) ?
		parm_pkg::TOTAL_W'(parm_pkg::RULES) : parm_pkg::TOTAL_W'(s_req.word_data);

	// Rule memory ports: written on a rule write request, read during the walk.
	assign rule_we          = acc && (s_tuser == parm_pkg::ACT_RULE) && idx_ok;
	assign rule_waddr       = parm_pkg::RULE_AW'(s_req.index);
	assign rule_wdata.flags = s_req.rule_flags;
	assign rule_wdata.gid   = s_req.group_id;
	assign rule_wdata.uid   = s_req.user_id;
	assign rule_wdata.lo    = s_req.port;
	assign rule_wdata.hi    = s_req.port_end;
	assign rule_re          = (state_q == ST_WALK) && (issue_q < total_q);
	assign rule_raddr       = issue_q[parm_pkg::RULE_AW-1:0];

	// Default map ports: the clearing pass and map write requests share the write port.
	assign map_we    = (state_q == ST_CLEAR) || (acc && (s_tuser == parm_pkg::ACT_MAP));
	assign map_waddr = (state_q == ST_CLEAR) ? clr_q : s_req.index;
	assign map_wdata = (state_q == ST_CLEAR) ? 32'd0 : s_req.word_data;
	assign map_re    = (state_q == ST_MAPRD);
	assign map_raddr = req_q.port[15:5];

	parm_ram #(
		.WIDTH($bits(parm_pkg::rule_t)),
		.DEPTH(parm_pkg::RULES)
	) u_rule_ram (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_waddr),
		.wdata (rule_wdata),
		.re    (rule_re),
		.raddr (rule_raddr),
		.rdata (rule_rdata)
	);

	parm_ram #(
		.WIDTH(32),
		.DEPTH(parm_pkg::MAP_WORDS)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	parm_rule_eval u_eval (
		.rule (rule_rdata),
		.req  (req_q),
		.ev   (ev)
	);

	// A matching rule decides unless it is a log rule without deny, which only marks.
	assign decide = (state_q == ST_WALK) && ev_v_s1 && ev.hit && (ev.deny || !ev.log);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			total_q   <= '0;
			issue_q   <= '0;
			ev_v_s1   <= 1'b0;
			log_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == parm_pkg::MAP_AW'(parm_pkg::MAP_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						if (s_tuser == parm_pkg::ACT_CHECK) begin
							issue_q <= '0;
							ev_v_s1 <= 1'b0;
							log_q   <= 1'b0;
							state_q <= ST_WALK;
						end else begin
							if (s_tuser == parm_pkg::ACT_COUNT) begin
								total_q <= total_d;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					if (rule_re) begin
						issue_q <= issue_q + 1'b1;
					end
					if (decide) begin
						ev_v_s1 <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						ev_v_s1 <= rule_re;
						if (ev_v_s1 && ev.hit) begin
							log_q <= 1'b1;
						end
						if (!rule_re && !ev_v_s1) begin
							state_q <= ST_MAPRD;
						end
					end
				end
				ST_MAPRD: begin
					state_q <= ST_MAPCHK;
				end
				ST_MAPCHK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= s_req;
			res_q <= '0;
		end
		if (rule_re) begin
			ev_idx_s1 <= rule_raddr;
		end
		if (decide) begin
			res_q.verdict    <= ev.deny;
			res_q.log_hit    <= log_q;
			res_q.by_default <= 1'b0;
			res_q.rule_hit   <= 10'(ev_idx_s1);
		end
		if (state_q == ST_MAPCHK) begin
			res_q.verdict    <= map_rdata[req_q.port[4:0]] && !req_q.has_bind_cap;
			res_q.log_hit    <= log_q;
			res_q.by_default <= 1'b1;
			res_q.rule_hit   <= '0;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	`PARM_ASSERT_IMP(a_no_take_in_clear, clk, arst_n, state_q == ST_CLEAR, !s_tready)
	`PARM_ASSERT(a_rule_port_excl, clk, arst_n, !(rule_we && rule_re))
	`PARM_ASSERT(a_map_port_excl, clk, arst_n, !(map_we && map_re))
	`PARM_ASSERT_IMP(a_issue_bound, clk, arst_n, state_q == ST_WALK, issue_q <= total_q)
	`PARM_ASSERT_NXT(a_take_leaves_idle, clk, arst_n, acc, state_q != ST_IDLE)

endmodule

// ===== rtl/parm_ram.sv =====
// Generic synchronous RAM: one write port, one read port, registered read data.
module parm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/parm_rule_eval.sv =====
// Tests one rule read from the rule memory against the latched check request.
module parm_rule_eval (
	input  parm_pkg::rule_t rule,
	input  parm_pkg::req_t  req,
	output parm_pkg::eval_t ev
);

	logic uid_ok;
	logic grp_ok;
	logic fam_ok;
	logic prt_ok;
	logic rng_ok;

	always_comb begin
		uid_ok = !rule.flags[parm_pkg::F_UID] || (rule.uid == req.user_id);
		grp_ok = !rule.flags[parm_pkg::F_GRP] || (rule.gid == req.group_id) ||
			(rule.gid == req.extra_group);
		fam_ok = req.is_ipv6 ?
			(rule.flags[parm_pkg::F_TCP6] | rule.flags[parm_pkg::F_UDP6]) :
			(rule.flags[parm_pkg::F_TCP4] | rule.flags[parm_pkg::F_UDP4]);
		prt_ok = ((req.protocol == parm_pkg::PROTO_TCP) &&
				(rule.flags[parm_pkg::F_TCP4] | rule.flags[parm_pkg::F_TCP6])) ||
			((req.protocol == parm_pkg::PROTO_UDP) &&
				(rule.flags[parm_pkg::F_UDP4] | rule.flags[parm_pkg::F_UDP6]));
		rng_ok = (req.port >= rule.lo) && (req.port <= rule.hi);
		ev.hit  = uid_ok && grp_ok && fam_ok && prt_ok && rng_ok;
		ev.deny = rule.flags[parm_pkg::F_DENY];
		ev.log  = rule.flags[parm_pkg::F_LOG];
	end

endmodule

// ===== verif/tb_port_access_rule_matcher.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the port access rule matcher, with its own first-match predictor.
module tb_port_access_rule_matcher;
	import parm_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 64;

	localparam logic [7:0] FL_TCP4 = 8'd1 << F_TCP4;
	localparam logic [7:0] FL_UDP4 = 8'd1 << F_UDP4;
	localparam logic [7:0] FL_TCP6 = 8'd1 << F_TCP6;
	localparam logic [7:0] FL_UDP6 = 8'd1 << F_UDP6;
	localparam logic [7:0] FL_UID  = 8'd1 << F_UID;
	localparam logic [7:0] FL_GRP  = 8'd1 << F_GRP;
	localparam logic [7:0] FL_LOG  = 8'd1 << F_LOG;
	localparam logic [7:0] FL_DENY = 8'd1 << F_DENY;
	localparam logic [7:0] FL_ANY_PROTO = FL_TCP4 | FL_UDP4 | FL_TCP6 | FL_UDP6;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;

	// Shadow copy of the block's state, updated as each request is taken.
	rule_t       rule_table [RULES];
	bit          rule_written [RULES];
	bit [31:0]   map_words [MAP_WORDS];
	int unsigned active_rules;

	res_t        pending_verdicts [$];
	int          error_count;
	int          burst_left;
	bit          no_gaps;
	bit          rx_always_ready;
	logic [15:0] stall_pattern = 16'hFFFF;
	int          stall_pos;
	int unsigned cycle_count;

	port_access_rule_matcher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_port_access_rule_matcher failed");
		$finish;
	end

	// Walks the shadow rule table first-match. Sets stray when the walk would reach a
	// slot that was never written, so that such a check is never sent.
	function automatic res_t predict_verdict(input req_t q, output bit stray);
		res_t  r;
		rule_t ru;
		bit    decided;
		bit    fam;
		bit    prt;
		r = '0;
		decided = 1'b0;
		stray = 1'b0;
		for (int i = 0; i < active_rules; i++) begin
			if (!rule_written[i]) begin
				stray = 1'b1;
				break;
			end
			ru = rule_table[i];
			if (ru.flags[F_UID] && q.user_id != ru.uid)
				continue;
			if (ru.flags[F_GRP] && ru.gid != q.group_id && ru.gid != q.extra_group)
				continue;
			fam = q.is_ipv6 ? (ru.flags[F_TCP6] | ru.flags[F_UDP6])
			                : (ru.flags[F_TCP4] | ru.flags[F_UDP4]);
			prt = (q.protocol == PROTO_TCP && (ru.flags[F_TCP4] | ru.flags[F_TCP6])) ||
			      (q.protocol == PROTO_UDP && (ru.flags[F_UDP4] | ru.flags[F_UDP6]));
			if (!fam || !prt || q.port < ru.lo || q.port > ru.hi)
				continue;
			if (ru.flags[F_DENY]) begin
				// A deny rule's own log bit is ignored.
				r.verdict = 1'b1;
				r.rule_hit = 10'(i);
				decided = 1'b1;
				break;
			end else if (ru.flags[F_LOG]) begin
				r.log_hit = 1'b1;
			end else begin
				r.rule_hit = 10'(i);
				decided = 1'b1;
				break;
			end
		end
		if (!decided) begin
			r.by_default = 1'b1;
			r.rule_hit = '0;
			r.verdict = map_words[q.port[15:5]][q.port[4:0]] & ~q.has_bind_cap;
		end
		return r;
	endfunction

	function automatic void commit_request(input logic [1:0] act, input req_t q);
		res_t  r;
		rule_t ru;
		bit    stray;
		r = '0;
		case (act)
			ACT_RULE: begin
				if (q.index < RULES) begin
					ru.flags = q.rule_flags;
					ru.gid = q.group_id;
					ru.uid = q.user_id;
					ru.lo = q.port;
					ru.hi = q.port_end;
					rule_table[q.index[RULE_AW-1:0]] = ru;
					rule_written[q.index[RULE_AW-1:0]] = 1'b1;
				end
			end
			ACT_COUNT: active_rules = (q.word_data > 32'(RULES)) ? RULES : q.word_data;
			ACT_MAP: map_words[q.index] = q.word_data;
			default: r = predict_verdict(q, stray);
		endcase
		pending_verdicts.push_back(r);
	endfunction

	// Sends one request inside the current burst, opening a new burst after a gap when
	// the last one is used up. The shadow state moves on when the request is taken.
	task automatic send_request(input logic [1:0] act, input req_t q);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= q;
		do @(posedge clk); while (!s_tready);
		commit_request(act, q);
	endtask

	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	function automatic req_t random_request();
		req_t q;
		q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		q.pad = '0;
		return q;
	endfunction

	function automatic logic [31:0] random_id();
		case ($urandom_range(0, 3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1000, 1003);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] random_port();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 1100));
			1: return 16'($urandom_range(64400, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	// Sends a check unless its walk would reach an unwritten slot; a stray check is retried as TCP,
	// since the saturation phase keeps a TCP/UDP catch-all in slot 0.
	task automatic send_check(input req_t q);
		res_t r;
		bit   stray;
		r = predict_verdict(q, stray);
		if (stray) begin
			q.protocol = PROTO_TCP;
			r = predict_verdict(q, stray);
		end
		if (!stray)
			send_request(ACT_CHECK, q);
	endtask

	task automatic check_port(input logic [15:0] port, input logic v6, input logic [7:0] proto,
			input logic [31:0] uid, input logic [31:0] gid, input logic [31:0] xgid,
			input logic cap);
		req_t q;
		q = random_request();
		q.port = port;
		q.is_ipv6 = v6;
		q.protocol = proto;
		q.user_id = uid;
		q.group_id = gid;
		q.extra_group = xgid;
		q.has_bind_cap = cap;
		send_check(q);
	endtask

	task automatic load_rule(input int slot, input logic [7:0] flags, input logic [15:0] lo,
			input logic [15:0] hi, input logic [31:0] uid, input logic [31:0] gid);
		req_t q;
		q = random_request();
		q.index = 11'(slot);
		q.rule_flags = flags;
		q.port = lo;
		q.port_end = hi;
		q.user_id = uid;
		q.group_id = gid;
		send_request(ACT_RULE, q);
	endtask

	task automatic set_rule_count(input logic [31:0] n);
		req_t q;
		q = random_request();
		q.word_data = n;
		send_request(ACT_COUNT, q);
	endtask

	task automatic write_map_word(input int idx, input logic [31:0] data);
		req_t q;
		q = random_request();
		q.index = 11'(idx);
		q.word_data = data;
		send_request(ACT_MAP, q);
	endtask

	function automatic req_t make_random_rule(input int slot);
		req_t q;
		int   span;
		q = random_request();
		q.index = 11'(slot);
		// Identity tests and deny/log are kept rarer so that walks reach further.
		if ($urandom_range(0, 3) != 0) q.rule_flags[F_UID] = 1'b0;
		if ($urandom_range(0, 3) != 0) q.rule_flags[F_GRP] = 1'b0;
		if ($urandom_range(0, 2) != 0) q.rule_flags[F_DENY] = 1'b0;
		if ($urandom_range(0, 2) != 0) q.rule_flags[F_LOG] = 1'b0;
		q.user_id = random_id();
		q.group_id = random_id();
		case ($urandom_range(0, 7))
			0: ; // fully random ends, often an inverted range
			1: begin
				q.port = 16'h0000;
				q.port_end = 16'hFFFF;
			end
			default: begin
				q.port = random_port();
				span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000)
				                                  : $urandom_range(0, 300);
				q.port_end = (int'(q.port) + span > 65535) ? 16'hFFFF : 16'(int'(q.port) + span);
			end
		endcase
		return q;
	endfunction

	// Most checks are aimed at a live rule so that they match; the rest are noise.
	function automatic req_t make_random_check();
		req_t  q;
		rule_t ru;
		int    k;
		q = random_request();
		q.user_id = random_id();
		q.group_id = random_id();
		q.extra_group = random_id();
		k = (active_rules > 0) ? $urandom_range(active_rules - 1, 0) : 0;
		if (active_rules > 0 && rule_written[k] && $urandom_range(0, 9) < 7) begin
			ru = rule_table[k];
			q.port = (ru.lo <= ru.hi) ? 16'($urandom_range(ru.hi, ru.lo)) : random_port();
			if ($urandom_range(0, 3) != 0) q.user_id = ru.uid;
			if ($urandom_range(0, 1)) q.group_id = ru.gid;
			else if ($urandom_range(0, 2) != 0) q.extra_group = ru.gid;
			q.protocol = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
		end else begin
			q.port = random_port();
			case ($urandom_range(0, 3))
				0: q.protocol = PROTO_TCP;
				1: q.protocol = PROTO_UDP;
				default: ; // random protocol, almost never TCP or UDP
			endcase
		end
		return q;
	endfunction

	task automatic build_rule_table(input int n);
		for (int i = 0; i < n; i++)
			send_request(ACT_RULE, make_random_rule(i));
		set_rule_count(n);
	endtask

	task automatic run_random_checks(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				write_map_word($urandom_range(0, MAP_WORDS - 1), $urandom);
			send_check(make_random_check());
		end
	endtask

	// Empty table and cleared map: every check is allowed by the default map.
	task automatic test_reset_state();
		check_port(16'h0000, 1'b0, PROTO_TCP, 32'h0, 32'h0, 32'h0, 1'b0);
		check_port(16'hFFFF, 1'b1, PROTO_UDP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		check_port(random_port(), 1'b0, 8'hFF, $urandom, $urandom, $urandom, 1'b1);
		set_rule_count(32'd0);
	endtask

	task automatic test_directed_rules();
		// Default map bits at both ends of the port space.
		write_map_word(0, 32'h8000_0001);
		write_map_word(MAP_WORDS - 1, 32'hFFFF_FFFF);
		check_port(16'hFFFF, 1'b0, PROTO_TCP, 32'h0, 32'h0, 32'h0, 1'b0);
		check_port(16'hFFFF, 1'b1, PROTO_UDP, 32'h0, 32'h0, 32'h0, 1'b1);
		check_port(16'd0, 1'b0, PROTO_TCP, 32'h0, 32'h0, 32'h0, 1'b0);
		check_port(16'd1, 1'b0, PROTO_TCP, 32'h0, 32'h0, 32'h0, 1'b0);
		check_port(16'd31, 1'b1, PROTO_TCP, 32'h0, 32'h0, 32'h0, 1'b0);

		load_rule(0, FL_LOG | FL_TCP4 | FL_TCP6, 16'd100, 16'd200, 32'h0, 32'h0);
		load_rule(1, FL_UDP4 | FL_UID | FL_LOG | FL_DENY, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
		// Mixed family and protocol flags.
		load_rule(2, FL_TCP4 | FL_UDP6 | FL_GRP, 16'd50, 16'd60, 32'd7, 32'h1234);
		// Inverted range never matches.
		load_rule(3, FL_ANY_PROTO, 16'd500, 16'd400, 32'h0, 32'h0);
		load_rule(4, FL_ANY_PROTO, 16'd0, 16'hFFFF, 32'h0, 32'h0);
		// Out-of-range slot: must not alias onto slot 1.
		load_rule(RULES + 1, FL_ANY_PROTO | FL_DENY, 16'd0, 16'hFFFF, 32'h0, 32'h0);

		set_rule_count(32'd2);
		check_port(16'd7000, 1'b0, PROTO_UDP, 32'd5, 32'd5, 32'd5, 1'b0);
		set_rule_count(32'd1);
		check_port(16'd150, 1'b0, PROTO_TCP, 32'd5, 32'd5, 32'd5, 1'b0);

		set_rule_count(32'd5);
		check_port(16'd150, 1'b0, PROTO_TCP, 32'd5, 32'd5, 32'd5, 1'b0);
		check_port(16'd55, 1'b0, PROTO_UDP, 32'hFFFF_FFFF, 32'd9, 32'd9, 1'b0);
		check_port(16'd55, 1'b0, PROTO_UDP, 32'd3, 32'h1234, 32'd9, 1'b0);
		check_port(16'd55, 1'b0, PROTO_UDP, 32'd3, 32'd9, 32'h1234, 1'b0);
		check_port(16'd55, 1'b1, PROTO_TCP, 32'd3, 32'h1234, 32'd9, 1'b0);
		check_port(16'd450, 1'b1, PROTO_TCP, 32'd3, 32'd9, 32'd9, 1'b0);
		check_port(16'd0, 1'b0, PROTO_ICMP, 32'd3, 32'd9, 32'd9, 1'b0);
	endtask

	task automatic test_default_map();
		int words [16];
		int w;
		set_rule_count(32'd0);
		for (int i = 0; i < 16; i++) begin
			words[i] = (i == 0) ? MAP_WORDS - 1 : $urandom_range(0, MAP_WORDS - 1);
			write_map_word(words[i], $urandom);
		end
		for (int i = 0; i < 30; i++) begin
			w = words[$urandom_range(0, 15)];
			check_port({w[10:0], 5'($urandom)}, 1'($urandom), 8'($urandom),
				$urandom, $urandom, $urandom, 1'($urandom));
		end
	endtask

	task automatic test_random_rule_tables();
		int n;
		for (int phase = 0; phase < 6; phase++) begin
			n = (phase == 5) ? 48 : $urandom_range(1, 24);
			build_rule_table(n);
			// Stray writes anywhere, including slots past the table that are ignored.
			for (int i = 0; i < 2; i++)
				send_request(ACT_RULE, make_random_rule($urandom_range(0, 2047)));
			if ($urandom_range(0, 3) == 0)
				set_rule_count($urandom_range(0, n));
			run_random_checks($urandom_range(32, 40));
		end
	endtask

	// The sender holds off until every result is back, then resumes.
	task automatic test_drain_pause();
		build_rule_table(12);
		run_random_checks(20);
		wait_until_drained();
		run_random_checks(20);
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		rx_always_ready = 1'b1;
		build_rule_table(16);
		run_random_checks(40);
		no_gaps = 1'b0;
		rx_always_ready = 1'b0;
	endtask

	// Counts above the table size saturate; a catch-all in slot 0 keeps the walk short.
	task automatic test_count_saturation();
		logic [31:0] counts [4];
		counts = '{32'd1024, 32'd1025, 32'h0000_0800, 32'hFFFF_FFFF};
		load_rule(0, FL_ANY_PROTO, 16'd0, 16'hFFFF, $urandom, $urandom);
		for (int i = 0; i < 4; i++) begin
			set_rule_count(counts[i]);
			for (int j = 0; j < 4; j++)
				check_port(random_port(), 1'($urandom), $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP,
					$urandom, $urandom, $urandom, 1'($urandom));
		end
		set_rule_count(32'd0);
	endtask

	// Receiver stalls follow a 16-bit pattern that is redrawn each time it runs out.
	always @(posedge clk) begin
		if (rx_always_ready) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= stall_pattern[stall_pos];
			if (stall_pos == 15) begin
				stall_pos <= 0;
				case ($urandom_range(0, 3))
					0: stall_pattern <= 16'hFFFF;
					1: stall_pattern <= 16'($urandom);
					2: stall_pattern <= 16'($urandom | $urandom);
					default: stall_pattern <= 16'($urandom & $urandom);
				endcase
			end else begin
				stall_pos <= stall_pos + 1;
			end
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		res_t seen;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata[$bits(res_t)-1:0];
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result with no request pending, expected none, got %h",
					$time, m_tdata);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("verdict", want.verdict, seen.verdict);
				check_field("log_hit", want.log_hit, seen.log_hit);
				check_field("by_default", want.by_default, seen.by_default);
				check_field("rule_hit", want.rule_hit, seen.rule_hit);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_CHECK;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed_rules();
		test_default_map();
		test_random_rule_tables();
		test_drain_pause();
		test_back_to_back();
		test_count_saturation();

		wait_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_port_access_rule_matcher passed");
		else
			$display("tb_port_access_rule_matcher failed");
		$finish;
	end

endmodule
